/* design/sil_pkg.sv */
// Package for the sorted insertion list: widths, codes, controller types.
`default_nettype none

package sil_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int KEY_BITS_DEF = 32;

   localparam int CMD_W  = 2;
   localparam int KEY_W  = 32;
   localparam int POS_W  = 4;
   localparam int DATA_W = 32;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_type;

endpackage

`default_nettype wire

/* design/sil_datapath.sv */
// Datapath: row of compare-and-shift cells, count, operand and result registers.
`default_nettype none

module sil_datapath #(
   parameter int CAPACITY = sil_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = sil_pkg::KEY_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sil_pkg::ctrl_type             ctrl,
   input  wire logic [sil_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [sil_pkg::KEY_W-1:0]     req_key,
   input  wire logic [sil_pkg::POS_W-1:0]     req_position,
   output logic      [sil_pkg::DATA_W-1:0]    rsp_data,
   output logic      [sil_pkg::STAT_W-1:0]    rsp_status,
   output logic      [sil_pkg::OCC_W-1:0]     rsp_occupancy
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > sil_pkg::POS_W) ? CNT_W : sil_pkg::POS_W;

   logic [sil_pkg::CMD_W-1:0]  cmd_ff;
   logic [KEY_BITS-1:0]        key_ff;
   logic [sil_pkg::POS_W-1:0]  pos_ff;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [KEY_BITS-1:0]        entry_ff [CAPACITY];
   logic [KEY_BITS-1:0]        entry_in [CAPACITY];
   logic [sil_pkg::DATA_W-1:0] data_ff, data_in;
   logic [sil_pkg::STAT_W-1:0] status_ff, status_in;

   logic [CAPACITY-1:0] lt;
   logic                full, in_range, insert_go, remove_go;

   assign full      = count_ff >= CNT_W'(CAPACITY);
   assign in_range  = CMP_W'(pos_ff) < CMP_W'(count_ff);
   assign insert_go = ctrl.execute && (cmd_ff == sil_pkg::CMD_INSERT) && !full;
   assign remove_go = ctrl.execute && (cmd_ff == sil_pkg::CMD_REMOVE) && in_range;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic shift_dn;

      assign lt[i] = (CNT_W'(i) < count_ff) && (entry_ff[i] < key_ff);
      assign shift_dn = remove_go && (CMP_W'(i) >= CMP_W'(pos_ff));

      always_comb begin
         entry_in[i] = entry_ff[i];
         if (insert_go && !lt[i]) begin
            if (i == 0) begin
               entry_in[i] = key_ff;
            end else begin
               entry_in[i] = lt[(i == 0) ? 0 : i - 1] ? key_ff : entry_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (shift_dn && (i < CAPACITY - 1)) begin
            entry_in[i] = entry_ff[(i < CAPACITY - 1) ? i + 1 : i];
         end
      end

      always_ff @(posedge clock) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (insert_go) begin
         count_in = count_ff + CNT_W'(1);
      end else if (remove_go) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      data_in   = '0;
      status_in = sil_pkg::STAT_OK;
      case (cmd_ff)
         sil_pkg::CMD_INSERT: begin
            if (full) begin
               status_in = sil_pkg::STAT_FULL;
            end
         end
         sil_pkg::CMD_LOOKUP: begin
            if (in_range) begin
               data_in = sil_pkg::DATA_W'(entry_ff[IDX_W'(pos_ff)]);
            end else begin
               status_in = sil_pkg::STAT_RANGE;
            end
         end
         sil_pkg::CMD_REMOVE: begin
            if (!in_range) begin
               status_in = sil_pkg::STAT_RANGE;
            end
         end
         default: begin
            status_in = sil_pkg::STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff <= req_cmd;
         key_ff <= KEY_BITS'(req_key);
         pos_ff <= req_position;
      end
      if (ctrl.execute) begin
         data_ff   <= data_in;
         status_ff <= status_in;
      end
   end

   assign rsp_data      = data_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = sil_pkg::OCC_W'(count_ff);

endmodule

`default_nettype wire

/* design/sil_controller.sv */
// Controller: sequences capture, execute and response of one word at a time.
`default_nettype none

module sil_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output sil_pkg::ctrl_type      ctrl
);

   sil_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sil_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sil_pkg::ST_EXEC;
            end
         end
         sil_pkg::ST_EXEC: begin
            state_in = sil_pkg::ST_RESP;
         end
         sil_pkg::ST_RESP: begin
            if (rsp_ready) begin
               state_in = sil_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sil_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      ctrl.capture = 1'b0;
      ctrl.execute = 1'b0;
      unique case (state_ff)
         sil_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            ctrl.capture = req_valid;
         end
         sil_pkg::ST_EXEC: begin
            ctrl.execute = 1'b1;
         end
         sil_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sil_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* design/sorted_insert_list.sv */
// Top level of the sorted insertion list: controller plus compare-and-shift datapath.
// A word accepted in idle is captured into the operand registers; in the execute state its
// result is registered, and it shows as the controller enters the response state. The
// controller holds one word at a time while the cell row inserts or removes in execute.
// Reset (synchronous, active high) empties the list and returns the controller to idle;
// stored keys are not cleared, only entries below the count are ever returned.
`default_nettype none

module sorted_insert_list #(
   parameter int CAPACITY = sil_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = sil_pkg::KEY_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [sil_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [sil_pkg::KEY_W-1:0]     req_key,
   input  wire logic [sil_pkg::POS_W-1:0]     req_position,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [sil_pkg::DATA_W-1:0]    rsp_data,
   output logic      [sil_pkg::STAT_W-1:0]    rsp_status,
   output logic      [sil_pkg::OCC_W-1:0]     rsp_occupancy
);

   sil_pkg::ctrl_type ctrl;

   sil_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   sil_datapath #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .req_cmd       (req_cmd),
      .req_key       (req_key),
      .req_position  (req_position),
      .rsp_data      (rsp_data),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

`default_nettype wire

/* design/sil_checker.sv */
// Port checker for the sorted insertion list and its bind to the top level.
`default_nettype none

module sil_checker #(
   parameter int CAPACITY = sil_pkg::CAPACITY_DEF
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [sil_pkg::DATA_W-1:0] rsp_data,
   input wire logic [sil_pkg::STAT_W-1:0] rsp_status,
   input wire logic [sil_pkg::OCC_W-1:0]  rsp_occupancy
);

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("result not shown two cycles after accept");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("new word taken while result pending");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sil_pkg::STAT_OK |-> rsp_data == '0)
      else $error("error result carries nonzero data");

   a_occ_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_occupancy) <= CAPACITY || CAPACITY > 31)
      else $error("occupancy above capacity");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)
         && $stable(rsp_status) && $stable(rsp_occupancy))
      else $error("stalled result changed");

endmodule

bind sorted_insert_list sil_checker #(.CAPACITY(CAPACITY)) u_sil_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_data      (rsp_data),
   .rsp_status    (rsp_status),
   .rsp_occupancy (rsp_occupancy)
);

`default_nettype wire
